/* rtl/lse_pkg.sv */
// Shared types and constants of the LED scanner effect.
// No dependencies; used by lse_ctrl, lse_datapath and led_scanner_effect.
package lse_pkg;

    // Item command codes
    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_RENDER = 2'd1,
        CMD_START  = 2'd2,
        CMD_STOP   = 2'd3
    } t_cmd;

    // Configuration register indexes
    localparam logic [1:0] CFG_CYCLE_TIME = 2'd0;
    localparam logic [1:0] CFG_TAIL_LEDS  = 2'd1;
    localparam logic [1:0] CFG_LED_COUNT  = 2'd2;

    // Configuration reset values
    localparam logic [15:0] RST_CYCLE_TIME = 16'd3000;
    localparam logic [7:0]  RST_TAIL_LEDS  = 8'd15;
    localparam logic [10:0] RST_LED_COUNT  = 11'd0;

    // Largest strip the render path maps onto
    localparam logic [10:0] MAX_LEDS = 11'd1024;

    // Phase scale: 1.0 in Q1.16
    localparam logic [16:0] PHASE_ONE = 17'h10000;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_TICK_DIV,
        S_TICK_UPD,
        S_REN_MUL,
        S_REN_DIST,
        S_REN_CHK,
        S_REN_DIV,
        S_REN_FIN,
        S_EMIT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic latch;       // capture the input item
        logic clear_out;   // zero the result fields
        logic apply_ctl;   // start or stop
        logic tick_init;   // load the divider with the step division
        logic tick_upd;    // move and reflect the phase
        logic ren_mul;     // position = phase * (n - 1)
        logic ren_dist;    // head compare and distance
        logic head_set;    // mark the head LED
        logic ren_div_init;// load the divider with the tail ratio
        logic div_step;    // one quotient bit
        logic ren_fin;     // take the tail level
        logic emit;        // present the result
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        t_cmd cmd;
        logic running;
        logic ct_zero;
        logic step_sat;
        logic render_ok;
        logic head_hit;
        logic in_tail;
        logic div_last;
    } t_dp_stat;

endpackage

/* rtl/lse_ctrl.sv */
// Sequencer of the LED scanner effect: walks each item through the datapath.
// Depends on lse_pkg.
module lse_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  lse_pkg::t_dp_stat i_stat,
    output lse_pkg::t_dp_cmd  o_cmd,
    output logic              o_busy
);

    lse_pkg::t_state r_state;
    lse_pkg::t_state n_state;

    // Hold the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lse_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Decide the next state and the datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        case (r_state)
            lse_pkg::S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = lse_pkg::S_DECODE;
                end
            end
            lse_pkg::S_DECODE: begin
                o_cmd.clear_out = 1'b1;
                case (i_stat.cmd)
                    lse_pkg::CMD_TICK: begin
                        if (!i_stat.running || i_stat.ct_zero) begin
                            n_state = lse_pkg::S_EMIT;
                        end else begin
                            o_cmd.tick_init = 1'b1;
                            n_state = i_stat.step_sat ? lse_pkg::S_TICK_UPD
                                                      : lse_pkg::S_TICK_DIV;
                        end
                    end
                    lse_pkg::CMD_RENDER: begin
                        n_state = i_stat.render_ok ? lse_pkg::S_REN_MUL
                                                   : lse_pkg::S_EMIT;
                    end
                    default: begin
                        o_cmd.apply_ctl = 1'b1;
                        n_state         = lse_pkg::S_EMIT;
                    end
                endcase
            end
            lse_pkg::S_TICK_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = lse_pkg::S_TICK_UPD;
                end
            end
            lse_pkg::S_TICK_UPD: begin
                o_cmd.tick_upd = 1'b1;
                n_state        = lse_pkg::S_EMIT;
            end
            lse_pkg::S_REN_MUL: begin
                o_cmd.ren_mul = 1'b1;
                n_state       = lse_pkg::S_REN_DIST;
            end
            lse_pkg::S_REN_DIST: begin
                o_cmd.ren_dist = 1'b1;
                n_state        = lse_pkg::S_REN_CHK;
            end
            lse_pkg::S_REN_CHK: begin
                if (i_stat.head_hit) begin
                    o_cmd.head_set = 1'b1;
                    n_state        = lse_pkg::S_EMIT;
                end else if (i_stat.in_tail) begin
                    o_cmd.ren_div_init = 1'b1;
                    n_state            = lse_pkg::S_REN_DIV;
                end else begin
                    n_state = lse_pkg::S_EMIT;
                end
            end
            lse_pkg::S_REN_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = lse_pkg::S_REN_FIN;
                end
            end
            lse_pkg::S_REN_FIN: begin
                o_cmd.ren_fin = 1'b1;
                n_state       = lse_pkg::S_EMIT;
            end
            lse_pkg::S_EMIT: begin
                o_cmd.emit = 1'b1;
                n_state    = lse_pkg::S_IDLE;
            end
            default: begin
                n_state = lse_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/lse_datapath.sv */
// Datapath of the LED scanner effect: configuration, phase state, position
// multiplier and a shared restoring divider. Depends on lse_pkg.
module lse_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data,
    input  logic [1:0]        i_command,
    input  logic [15:0]       i_elapsed_ms,
    input  logic [9:0]        i_led_index,
    input  lse_pkg::t_dp_cmd  i_cmd,
    output lse_pkg::t_dp_stat o_stat,
    output logic [7:0]        o_red_level,
    output logic              o_drawn,
    output logic              o_is_head,
    output logic              o_valid
);

    // Configuration
    logic [15:0] r_cycle_time;
    logic [7:0]  r_tail_leds;
    logic [10:0] r_led_count;

    // Effect state
    logic [16:0] r_phase;
    logic        r_fwd;
    logic        r_running;

    // Latched item
    lse_pkg::t_cmd r_item_cmd;
    logic [15:0]   r_elapsed;
    logic [9:0]    r_idx;

    // Render intermediates
    logic [26:0] r_pos;
    logic [26:0] r_dist;
    logic        r_head_hit;

    // Divider
    logic [31:0] r_rem;
    logic [30:0] r_dvs;
    logic [15:0] r_quo;
    logic [3:0]  r_cnt;
    logic        r_step_sat;

    // Result
    logic [7:0] r_red;
    logic       r_drawn;
    logic       r_is_head;
    logic       r_valid;

    // Combinational helpers
    logic [10:0] n_leds;
    logic [9:0]  n_leds_m1;
    logic [26:0] n_pos;
    logic [26:0] n_head_sum;
    logic [26:0] n_here;
    logic [26:0] n_dist;
    logic [26:0] n_span;
    logic        n_in_tail;
    logic [23:0] n_tail_left;
    logic [31:0] n_tail_num;
    logic        n_div_ge;
    logic [16:0] n_step;
    logic [17:0] n_fsum;
    logic [17:0] n_bdiff;
    logic [17:0] n_fref;
    logic [17:0] n_bneg;

    // Clamp the strip length
    assign n_leds    = (r_led_count > lse_pkg::MAX_LEDS) ? lse_pkg::MAX_LEDS : r_led_count;
    assign n_leds_m1 = 10'(n_leds - 11'd1);

    // Position and distance
    assign n_pos      = 27'(r_phase) * 27'(n_leds_m1);
    assign n_head_sum = r_pos + 27'd32768;
    assign n_here     = {1'b0, r_idx, 16'b0};
    assign n_dist     = (n_here > r_pos) ? (n_here - r_pos) : (r_pos - n_here);
    assign n_span     = {3'b0, r_tail_leds, 16'b0};
    assign n_in_tail  = (r_tail_leds != 8'd0) && (r_dist <= n_span);

    // Tail numerator 255 * (span - d)
    assign n_tail_left = 24'(n_span - r_dist);
    assign n_tail_num  = {n_tail_left, 8'b0} - {8'b0, n_tail_left};

    // Divider compare
    assign n_div_ge = (r_rem >= {1'b0, r_dvs});

    // Phase move with reflection at both ends
    assign n_step  = r_step_sat ? lse_pkg::PHASE_ONE : {1'b0, r_quo};
    assign n_fsum  = {1'b0, r_phase} + {1'b0, n_step};
    assign n_bdiff = {1'b0, r_phase} - {1'b0, n_step};
    assign n_fref  = 18'h20000 - n_fsum;
    assign n_bneg  = 18'd0 - n_bdiff;

    // Status to the controller
    always_comb begin
        o_stat.cmd       = r_item_cmd;
        o_stat.running   = r_running;
        o_stat.ct_zero   = (r_cycle_time == 16'd0);
        o_stat.step_sat  = (r_elapsed >= r_cycle_time);
        o_stat.render_ok = r_running && (n_leds >= 11'd2) && ({1'b0, r_idx} < n_leds);
        o_stat.head_hit  = r_head_hit;
        o_stat.in_tail   = n_in_tail;
        o_stat.div_last  = (r_cnt == 4'd0);
    end

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cycle_time <= lse_pkg::RST_CYCLE_TIME;
            r_tail_leds  <= lse_pkg::RST_TAIL_LEDS;
            r_led_count  <= lse_pkg::RST_LED_COUNT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                lse_pkg::CFG_CYCLE_TIME: r_cycle_time <= i_cfg_data;
                lse_pkg::CFG_TAIL_LEDS:  r_tail_leds  <= i_cfg_data[7:0];
                lse_pkg::CFG_LED_COUNT:  r_led_count  <= i_cfg_data[10:0];
                default: begin
                end
            endcase
        end
    end

    // Update the effect state: start, stop and tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= '0;
            r_fwd     <= 1'b1;
            r_running <= 1'b0;
        end else begin
            if (i_cmd.apply_ctl) begin
                if (r_item_cmd == lse_pkg::CMD_START) begin
                    if (!r_running) begin
                        r_running <= 1'b1;
                        r_phase   <= '0;
                        r_fwd     <= 1'b1;
                    end
                end else begin
                    r_running <= 1'b0;
                end
            end
            if (i_cmd.tick_upd) begin
                if (r_fwd) begin
                    if (n_fsum >= {1'b0, lse_pkg::PHASE_ONE}) begin
                        r_phase <= n_fref[16:0];
                        r_fwd   <= 1'b0;
                    end else begin
                        r_phase <= n_fsum[16:0];
                    end
                end else begin
                    if (n_bdiff[17] || (n_bdiff == 18'd0)) begin
                        r_phase <= n_bneg[16:0];
                        r_fwd   <= 1'b1;
                    end else begin
                        r_phase <= n_bdiff[16:0];
                    end
                end
            end
        end
    end

    // Capture the item and the render intermediates
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_item_cmd <= lse_pkg::t_cmd'(i_command);
            r_elapsed  <= i_elapsed_ms;
            r_idx      <= i_led_index;
        end
        if (i_cmd.ren_mul) begin
            r_pos <= n_pos;
        end
        if (i_cmd.ren_dist) begin
            r_dist     <= n_dist;
            r_head_hit <= (n_head_sum[26:16] == {1'b0, r_idx});
        end
    end

    // Shared restoring divider, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.tick_init) begin
            r_rem      <= {r_elapsed, 16'b0};
            r_dvs      <= {r_cycle_time, 15'b0};
            r_quo      <= '0;
            r_cnt      <= 4'd15;
            r_step_sat <= (r_elapsed >= r_cycle_time);
        end else if (i_cmd.ren_div_init) begin
            r_rem <= n_tail_num;
            r_dvs <= {r_tail_leds, 23'b0};
            r_quo <= '0;
            r_cnt <= 4'd7;
        end else if (i_cmd.div_step) begin
            if (n_div_ge) begin
                r_rem <= r_rem - {1'b0, r_dvs};
            end
            r_quo <= {r_quo[14:0], n_div_ge};
            r_dvs <= {1'b0, r_dvs[30:1]};
            r_cnt <= r_cnt - 4'd1;
        end
    end

    // Build the result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_out) begin
            r_red     <= '0;
            r_drawn   <= 1'b0;
            r_is_head <= 1'b0;
        end else begin
            if (i_cmd.ren_mul) begin
                r_drawn <= 1'b1;
            end
            if (i_cmd.head_set) begin
                r_red     <= 8'd255;
                r_is_head <= 1'b1;
            end
            if (i_cmd.ren_fin) begin
                r_red <= r_quo[7:0];
            end
        end
    end

    // Strobe the result for one cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
        end
    end

    assign o_red_level = r_red;
    assign o_drawn     = r_drawn;
    assign o_is_head   = r_is_head;
    assign o_valid     = r_valid;

endmodule

/* rtl/led_scanner_effect.sv */
// Top level of the LED scanner effect: controller plus datapath.
// Depends on lse_pkg, lse_ctrl and lse_datapath.
//
//  channel   direction  handshake               payload
//  item      in         i_start & !o_busy       i_command, i_elapsed_ms, i_led_index
//  result    out        o_valid (one cycle)     o_red_level, o_drawn, o_is_head
//  config    in         i_cfg_we                i_cfg_index, i_cfg_data
//
// One item at a time. A tick that divides and a tail LED take longer to strobe
// their result than start and stop, since both pass through the shared restoring
// divider, one quotient bit per cycle.
// o_busy falls in the cycle of the strobe, so the next item may be taken then.
// Synchronous active-low reset clears the controller, configuration and state.
// The receiver cannot stall; every result is taken in its strobe cycle.
module led_scanner_effect (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_command,
    input  logic [15:0] i_elapsed_ms,
    input  logic [9:0]  i_led_index,
    output logic        o_valid,
    output logic [7:0]  o_red_level,
    output logic        o_drawn,
    output logic        o_is_head
);

    lse_pkg::t_dp_cmd  w_cmd;
    lse_pkg::t_dp_stat w_stat;

    // Sequence each item
    lse_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (o_busy)
    );

    // Compute phase, position and levels
    lse_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_command    (i_command),
        .i_elapsed_ms (i_elapsed_ms),
        .i_led_index  (i_led_index),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .o_red_level  (o_red_level),
        .o_drawn      (o_drawn),
        .o_is_head    (o_is_head),
        .o_valid      (o_valid)
    );

endmodule

/* dv/led_scanner_effect_tb.sv */
// Self-checking testbench for the LED scanner effect (led_scanner_effect).
// Depends on lse_pkg and the RTL. A behavioral scanner model predicts every pixel
// result, and a monitor checks each one against that prediction.
`timescale 1ns / 100ps

module led_scanner_effect_tb;
    import lse_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int SETTLE_CYCLE = 24;

    typedef struct {
        t_cmd        cmd;
        logic [15:0] elapsed;
        logic [9:0]  led_index;
        bit          wait_drain;
    } t_scan_item;

    typedef struct {
        logic [7:0] red;
        logic       drawn;
        logic       head;
    } t_pixel;

    // DUT ports; the inputs are all known from time zero
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [1:0]  i_cfg_index = CFG_CYCLE_TIME;
    logic [15:0] i_cfg_data  = '0;
    logic        i_start     = 1'b0;
    t_cmd        i_command   = CMD_TICK;
    logic [15:0] i_elapsed_ms = '0;
    logic [9:0]  i_led_index = '0;
    logic        o_busy;
    logic        o_valid;
    logic [7:0]  o_red_level;
    logic        o_drawn;
    logic        o_is_head;

    // Scanner model: configuration and sweep state
    logic [15:0] sweep_ms    = RST_CYCLE_TIME;
    logic [7:0]  tail_len    = RST_TAIL_LEDS;
    logic [10:0] strip_leds  = RST_LED_COUNT;
    logic [16:0] phase_q16   = '0;
    logic        heading_fwd = 1'b1;
    logic        scanning    = 1'b0;

    t_scan_item pending_items[$];
    t_pixel     expected_pixels[$];
    int         send_idle_pct = 0;
    int         gap_left = 0;
    int         mismatch_count = 0;
    int         cycle_count = 0;
    logic       took;
    t_scan_item next_item;

    led_scanner_effect u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_start      (i_start),
        .o_busy       (o_busy),
        .i_command    (i_command),
        .i_elapsed_ms (i_elapsed_ms),
        .i_led_index  (i_led_index),
        .o_valid      (o_valid),
        .o_red_level  (o_red_level),
        .o_drawn      (o_drawn),
        .o_is_head    (o_is_head)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Advance the sweep by one tick, reflecting at both ends
    task automatic advance_sweep(input logic [15:0] elapsed);
        logic [31:0]        quot;
        logic [16:0]        step;
        logic signed [18:0] p;
        if (scanning && sweep_ms != 16'd0) begin
            quot = {elapsed, 16'h0000} / {16'h0000, sweep_ms};
            step = (quot > 32'd65536) ? PHASE_ONE : quot[16:0];
            if (heading_fwd) begin
                p = $signed({2'b00, phase_q16}) + $signed({2'b00, step});
                if (p >= 19'sd65536) begin
                    p = 19'sd131072 - p;
                    heading_fwd = 1'b0;
                end
            end else begin
                p = $signed({2'b00, phase_q16}) - $signed({2'b00, step});
                if (p <= 19'sd0) begin
                    p = -p;
                    heading_fwd = 1'b1;
                end
            end
            phase_q16 = p[16:0];
        end
    endtask

    // Work out the pixel of one LED from the current sweep position
    function automatic t_pixel pixel_at(input logic [9:0] idx);
        t_pixel      px;
        logic [10:0] n;
        logic [26:0] pos;
        logic [26:0] head_pos;
        logic [26:0] here;
        logic [26:0] dist_q16;
        logic [23:0] span;
        logic [31:0] num;
        px = '{red: 8'd0, drawn: 1'b0, head: 1'b0};
        n = (strip_leds > MAX_LEDS) ? MAX_LEDS : strip_leds;
        if (scanning && n >= 11'd2 && {1'b0, idx} < n) begin
            px.drawn = 1'b1;
            pos = 27'(phase_q16) * 27'(n - 11'd1);
            head_pos = (pos + 27'd32768) >> 16;
            if ({17'd0, idx} == head_pos) begin
                px.red = 8'd255;
                px.head = 1'b1;
            end else begin
                here = {1'b0, idx, 16'h0000};
                dist_q16 = (here > pos) ? here - pos : pos - here;
                span = {tail_len, 16'h0000};
                if (span != 24'd0 && dist_q16 <= {3'd0, span}) begin
                    num = 32'd255 * ({8'd0, span} - {8'd0, dist_q16[23:0]});
                    px.red = 8'(num / {8'd0, span});
                end
            end
        end
        return px;
    endfunction

    // Update the scanner model with one accepted item and queue its pixel
    task automatic predict_scanner(input t_cmd cmd, input logic [15:0] elapsed,
                                   input logic [9:0] idx);
        t_pixel px;
        px = '{red: 8'd0, drawn: 1'b0, head: 1'b0};
        case (cmd)
            CMD_TICK:   advance_sweep(elapsed);
            CMD_RENDER: px = pixel_at(idx);
            CMD_START: begin
                if (!scanning) begin
                    scanning = 1'b1;
                    phase_q16 = '0;
                    heading_fwd = 1'b1;
                end
            end
            default:    scanning = 1'b0;
        endcase
        expected_pixels.push_back(px);
    endtask

    // Driver: present queued items, hold each until accepted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
            gap_left = 0;
        end else begin
            took = i_start && !o_busy;
            if (took) begin
                predict_scanner(i_command, i_elapsed_ms, i_led_index);
                if ($urandom_range(0, 99) < send_idle_pct)
                    gap_left = $urandom_range(1, 30);
            end else if (gap_left > 0 && !i_start) begin
                gap_left = gap_left - 1;
            end
            if (!i_start || took) begin
                if (pending_items.size() != 0 && gap_left == 0 &&
                    (!pending_items[0].wait_drain ||
                     (!o_valid && expected_pixels.size() == 0))) begin
                    next_item = pending_items.pop_front();
                    i_start      <= 1'b1;
                    i_command    <= next_item.cmd;
                    i_elapsed_ms <= next_item.elapsed;
                    i_led_index  <= next_item.led_index;
                end else begin
                    i_start <= 1'b0;
                end
            end
        end
    end

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Monitor: check each strobed pixel against the oldest prediction
    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && o_valid) begin
            if (expected_pixels.size() == 0) begin
                $display("%0t: unexpected item, expected none, actual red %0d drawn %0d head %0d",
                         $time, o_red_level, o_drawn, o_is_head);
                mismatch_count++;
            end else begin
                want = expected_pixels.pop_front();
                compare_field("red_level", want.red, o_red_level);
                compare_field("drawn", want.drawn, o_drawn);
                compare_field("is_head", want.head, o_is_head);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Wait until the block has drained every item, then let it settle
    task automatic wait_idle();
        while (pending_items.size() != 0 || i_start || o_busy ||
               expected_pixels.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLE) @(negedge i_clk);
    endtask

    // Write all three registers back to back, mirroring them in the model
    task automatic write_regs(input logic [15:0] cycle_ms, input logic [7:0] tail,
                              input logic [10:0] leds);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_CYCLE_TIME;
        i_cfg_data <= cycle_ms;
        sweep_ms = cycle_ms;
        @(posedge i_clk);
        i_cfg_index <= CFG_TAIL_LEDS;
        i_cfg_data <= {8'd0, tail};
        tail_len = tail;
        @(posedge i_clk);
        i_cfg_index <= CFG_LED_COUNT;
        i_cfg_data <= {5'd0, leds};
        strip_leds = leds;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic queue_item(input t_cmd cmd, input logic [15:0] elapsed,
                              input logic [9:0] idx, input bit drain);
        t_scan_item it;
        it.cmd = cmd;
        it.elapsed = elapsed;
        it.led_index = idx;
        it.wait_drain = drain;
        pending_items.push_back(it);
    endtask

    // Fill one phase: a start, then mostly ticks and renders with a few starts and stops
    task automatic queue_random_items(input int count, input int leds);
        t_scan_item it;
        int         roll;
        int         top_idx;
        top_idx = (leds > 1024) ? 1023 : leds - 1;
        queue_item(CMD_START, 16'($urandom_range(0, 65535)), 10'($urandom_range(0, 1023)), 1'b0);
        for (int k = 0; k < count; k++) begin
            roll = $urandom_range(0, 99);
            it.elapsed = 16'($urandom_range(0, 65535));
            it.led_index = 10'($urandom_range(0, 1023));
            it.wait_drain = ($urandom_range(0, 49) == 0);
            if (roll < 5) begin
                it.cmd = CMD_START;
            end else if (roll < 8) begin
                it.cmd = CMD_STOP;
            end else if (roll < 45) begin
                it.cmd = CMD_TICK;
                case ($urandom_range(0, 9))
                    0:       it.elapsed = 16'd0;
                    1:       it.elapsed = 16'hFFFF;
                    2, 3:    ;
                    default: it.elapsed = 16'($urandom_range(0, 600));
                endcase
            end else begin
                it.cmd = CMD_RENDER;
                if (top_idx >= 1 && $urandom_range(0, 99) < 85)
                    it.led_index = 10'($urandom_range(0, top_idx));
            end
            pending_items.push_back(it);
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: 40 LEDs, 1 s sweep, tail of 5
        write_regs(16'd1000, 8'd5, 11'd40);
        send_idle_pct = 0;
        queue_item(CMD_RENDER, 16'd0, 10'd0, 1'b0);     // render while stopped
        queue_item(CMD_TICK, 16'hFFFF, 10'd0, 1'b0);    // tick while stopped
        queue_item(CMD_STOP, 16'd0, 10'd0, 1'b0);       // stop while stopped
        queue_item(CMD_START, 16'd0, 10'd0, 1'b0);
        queue_item(CMD_RENDER, 16'd0, 10'd0, 1'b0);     // head at first LED
        queue_item(CMD_RENDER, 16'd0, 10'd3, 1'b0);     // tail
        queue_item(CMD_RENDER, 16'd0, 10'd5, 1'b0);     // tail edge
        queue_item(CMD_RENDER, 16'd0, 10'd39, 1'b0);    // out of tail reach
        queue_item(CMD_RENDER, 16'd0, 10'h3FF, 1'b0);   // beyond the strip
        queue_item(CMD_TICK, 16'd0, 10'd0, 1'b0);
        queue_item(CMD_TICK, 16'd250, 10'd0, 1'b0);     // quarter sweep
        queue_item(CMD_RENDER, 16'd0, 10'd10, 1'b0);
        queue_item(CMD_RENDER, 16'd0, 10'd9, 1'b0);
        queue_item(CMD_START, 16'd0, 10'd0, 1'b0);      // start while running
        queue_item(CMD_RENDER, 16'd0, 10'd12, 1'b0);
        queue_item(CMD_TICK, 16'hFFFF, 10'd0, 1'b0);    // saturated step, forward bounce
        queue_item(CMD_RENDER, 16'd0, 10'd29, 1'b0);
        queue_item(CMD_TICK, 16'hFFFF, 10'd0, 1'b1);    // backward bounce
        queue_item(CMD_TICK, 16'd750, 10'd0, 1'b0);     // lands exactly on the far end
        queue_item(CMD_RENDER, 16'd0, 10'd39, 1'b0);
        queue_item(CMD_RENDER, 16'd0, 10'd38, 1'b0);
        queue_item(CMD_TICK, 16'd1000, 10'd0, 1'b0);    // lands exactly on the near end
        queue_item(CMD_RENDER, 16'd0, 10'd0, 1'b0);
        queue_item(CMD_STOP, 16'd0, 10'd0, 1'b0);
        queue_item(CMD_RENDER, 16'd0, 10'd0, 1'b0);
        wait_idle();

        // Random phases over several register settings and idle rates
        write_regs(16'd3000, 8'd15, 11'd60);
        send_idle_pct = 0;
        queue_random_items(150, 60);
        wait_idle();

        write_regs(16'hFFFF, 8'd255, 11'd1024);
        send_idle_pct = 79;
        queue_random_items(150, 1024);
        wait_idle();

        // No tail, oversized strip, every tick with a nonzero elapsed time saturates
        write_regs(16'd1, 8'd0, 11'd2047);
        send_idle_pct = 19;
        queue_random_items(130, 2047);
        wait_idle();

        // Zero cycle time, single LED
        write_regs(16'd0, 8'd1, 11'd1);
        send_idle_pct = 0;
        queue_random_items(50, 1);
        wait_idle();

        write_regs(16'd500, 8'd3, 11'd2);
        send_idle_pct = 79;
        queue_random_items(80, 2);
        wait_idle();

        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* files.f */
rtl/lse_pkg.sv
rtl/lse_ctrl.sv
rtl/lse_datapath.sv
rtl/led_scanner_effect.sv
dv/led_scanner_effect_tb.sv
